@@ src/bffa_pkg.sv @@
// shared constants, types and codes of the bitmap first-fit block allocator
package bffa_pkg;

  localparam int NUM_BLOCKS = 256;
  localparam int MAX_PROCS  = 16;
  localparam int WORD_W     = 8;
  localparam int NUM_WORDS  = NUM_BLOCKS / WORD_W;

  localparam int BLK_W   = $clog2(NUM_BLOCKS);
  localparam int CNT_W   = $clog2(NUM_BLOCKS + 1);
  localparam int PROC_W  = $clog2(MAX_PROCS);
  localparam int LIMIT_W = PROC_W + 1;
  localparam int BIT_W   = $clog2(WORD_W);
  localparam int WIDX_W  = $clog2(NUM_WORDS);
  localparam int CTR_W   = 16;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(MAX_PROCS);

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic STATUS_DONE   = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_SETUP,
    ST_MARK,
    ST_FINISH
  } bffa_state_t;

  typedef struct packed {
    logic load;
    logic scan_start;
    logic scan_step;
    logic mark_start;
    logic mark_step;
    logic emit;
    logic reject;
  } bffa_cmd_t;

  typedef struct packed {
    logic is_free;
    logic index_ok;
    logic need_zero;
    logic held_zero;
    logic hit;
    logic scan_last;
    logic mark_last;
    logic out_busy;
  } bffa_stat_t;

endpackage

@@ src/bffa_intf.sv @@
// channel interfaces: request, result and configuration write
interface bffa_req_if;
  logic                          valid;
  logic                          ready;
  logic                          command;
  logic [bffa_pkg::PROC_W-1:0]   process;
  logic [bffa_pkg::CNT_W-1:0]    blocks_needed;

  modport source (output valid, output command, output process, output blocks_needed,
                  input ready);
  modport sink (input valid, input command, input process, input blocks_needed,
                output ready);
endinterface

interface bffa_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          status;
  logic [bffa_pkg::BLK_W-1:0]    start_block;
  logic [bffa_pkg::CNT_W-1:0]    used_blocks;
  logic [bffa_pkg::CNT_W-1:0]    free_blocks;
  logic [bffa_pkg::CTR_W-1:0]    allocations_done;
  logic [bffa_pkg::CTR_W-1:0]    frees_done;

  modport source (output valid, output status, output start_block, output used_blocks,
                  output free_blocks, output allocations_done, output frees_done,
                  input ready);
  modport sink (input valid, input status, input start_block, input used_blocks,
                input free_blocks, input allocations_done, input frees_done,
                output ready);
endinterface

interface bffa_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [bffa_pkg::LIMIT_W-1:0]  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ src/bffa_ctrl.sv @@
// controller state machine sequencing check, scan, mark and result
module bffa_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  bffa_pkg::bffa_stat_t stat,
  output bffa_pkg::bffa_cmd_t  cmd
);

  bffa_pkg::bffa_state_t state_r, state_nxt;
  logic                  rej_r, rej_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bffa_pkg::ST_IDLE;
      rej_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rej_r   <= rej_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    rej_nxt   = rej_r;
    unique case (state_r)
      bffa_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = bffa_pkg::ST_CHECK;
          rej_nxt   = 1'b0;
        end
      end
      bffa_pkg::ST_CHECK: begin
        if (!stat.index_ok || (!stat.is_free && stat.need_zero) ||
            (stat.is_free && stat.held_zero)) begin
          state_nxt = bffa_pkg::ST_FINISH;
          rej_nxt   = 1'b1;
        end else if (stat.is_free) begin
          state_nxt = bffa_pkg::ST_SETUP;
        end else begin
          state_nxt = bffa_pkg::ST_SCAN;
        end
      end
      bffa_pkg::ST_SCAN: begin
        if (stat.hit) begin
          state_nxt = bffa_pkg::ST_SETUP;
        end else if (stat.scan_last) begin
          state_nxt = bffa_pkg::ST_FINISH;
          rej_nxt   = 1'b1;
        end
      end
      bffa_pkg::ST_SETUP: begin
        state_nxt = bffa_pkg::ST_MARK;
      end
      bffa_pkg::ST_MARK: begin
        if (stat.mark_last) begin
          state_nxt = bffa_pkg::ST_FINISH;
        end
      end
      bffa_pkg::ST_FINISH: begin
        if (!stat.out_busy) begin
          state_nxt = bffa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bffa_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      bffa_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      bffa_pkg::ST_CHECK: begin
        cmd.scan_start = stat.index_ok && !stat.is_free && !stat.need_zero;
      end
      bffa_pkg::ST_SCAN: begin
        cmd.scan_step = 1'b1;
      end
      bffa_pkg::ST_SETUP: begin
        cmd.mark_start = 1'b1;
      end
      bffa_pkg::ST_MARK: begin
        cmd.mark_step = 1'b1;
      end
      bffa_pkg::ST_FINISH: begin
        cmd.emit   = !stat.out_busy;
        cmd.reject = rej_r;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

@@ src/bffa_dp.sv @@
// datapath: block map, per-process records, run search, marking and result register
module bffa_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bffa_pkg::bffa_cmd_t           cmd,
  output bffa_pkg::bffa_stat_t          stat,
  input  logic                          in_command,
  input  logic [bffa_pkg::PROC_W-1:0]   in_process,
  input  logic [bffa_pkg::CNT_W-1:0]    in_blocks_needed,
  input  logic                          cfg_valid,
  input  logic [bffa_pkg::LIMIT_W-1:0]  cfg_data,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic                          out_status,
  output logic [bffa_pkg::BLK_W-1:0]    out_start_block,
  output logic [bffa_pkg::CNT_W-1:0]    out_used_blocks,
  output logic [bffa_pkg::CNT_W-1:0]    out_free_blocks,
  output logic [bffa_pkg::CTR_W-1:0]    out_allocations_done,
  output logic [bffa_pkg::CTR_W-1:0]    out_frees_done
);

  logic [bffa_pkg::WORD_W-1:0]  map_r      [bffa_pkg::NUM_WORDS];
  logic [bffa_pkg::CNT_W-1:0]   held_len_r [bffa_pkg::MAX_PROCS];
  logic [bffa_pkg::BLK_W-1:0]   held_st_r  [bffa_pkg::MAX_PROCS];

  logic [bffa_pkg::LIMIT_W-1:0] limit_r;
  logic                         cmd_r;
  logic [bffa_pkg::PROC_W-1:0]  proc_r;
  logic [bffa_pkg::CNT_W-1:0]   need_r;

  logic [bffa_pkg::WIDX_W-1:0]  scan_w_r;
  logic [bffa_pkg::CNT_W-1:0]   run_r;
  logic [bffa_pkg::BLK_W-1:0]   first_r;
  logic [bffa_pkg::BLK_W-1:0]   start_r;

  logic [bffa_pkg::BLK_W-1:0]   lo_r;
  logic [bffa_pkg::CNT_W-1:0]   hi_r;
  logic [bffa_pkg::WIDX_W-1:0]  cur_w_r;

  logic [bffa_pkg::CNT_W-1:0]   used_r;
  logic [bffa_pkg::CTR_W-1:0]   grants_r;
  logic [bffa_pkg::CTR_W-1:0]   releases_r;
  logic                         out_vld_r;

  logic [bffa_pkg::CNT_W-1:0]   held_len;
  logic [bffa_pkg::BLK_W-1:0]   held_st;
  logic [bffa_pkg::WORD_W-1:0]  map_word;
  logic [bffa_pkg::WIDX_W-1:0]  map_idx;

  logic [bffa_pkg::CNT_W-1:0]   run_nxt;
  logic [bffa_pkg::BLK_W-1:0]   first_nxt;
  logic [bffa_pkg::BLK_W-1:0]   hit_start;
  logic                         hit;

  logic [bffa_pkg::BLK_W-1:0]   mark_lo;
  logic [bffa_pkg::CNT_W-1:0]   mark_len;
  logic [bffa_pkg::WORD_W-1:0]  mask;

  logic [bffa_pkg::CNT_W-1:0]   used_nxt;
  logic [bffa_pkg::CTR_W-1:0]   grants_nxt;
  logic [bffa_pkg::CTR_W-1:0]   releases_nxt;

  assign held_len = held_len_r[proc_r];
  assign held_st  = held_st_r[proc_r];

  // one map word read per cycle: the scan word or the word being marked
  assign map_idx  = cmd.scan_step ? scan_w_r : cur_w_r;
  assign map_word = map_r[map_idx];

  // first-fit over one word, carrying the free run across word boundaries
  always_comb begin
    run_nxt   = run_r;
    first_nxt = first_r;
    hit       = 1'b0;
    hit_start = first_r;
    for (int j = 0; j < bffa_pkg::WORD_W; j++) begin
      if (!hit) begin
        if (!map_word[j]) begin
          if (run_nxt == '0) begin
            first_nxt = {scan_w_r, bffa_pkg::BIT_W'(j)};
          end
          run_nxt = run_nxt + bffa_pkg::CNT_W'(1);
          if (run_nxt >= need_r) begin
            hit       = 1'b1;
            hit_start = first_nxt;
          end
        end else begin
          run_nxt = '0;
        end
      end
    end
  end

  assign mark_lo  = (cmd_r == bffa_pkg::CMD_FREE) ? held_st  : start_r;
  assign mark_len = (cmd_r == bffa_pkg::CMD_FREE) ? held_len : need_r;

  always_comb begin
    for (int j = 0; j < bffa_pkg::WORD_W; j++) begin
      mask[j] = ({1'b0, cur_w_r, bffa_pkg::BIT_W'(j)} >= {1'b0, lo_r}) &&
                ({1'b0, cur_w_r, bffa_pkg::BIT_W'(j)} <= hi_r);
    end
  end

  always_comb begin
    used_nxt     = used_r;
    grants_nxt   = grants_r;
    releases_nxt = releases_r;
    if (!cmd.reject) begin
      if (cmd_r == bffa_pkg::CMD_FREE) begin
        used_nxt     = (used_r >= held_len) ? used_r - held_len : '0;
        releases_nxt = releases_r + bffa_pkg::CTR_W'(1);
      end else begin
        used_nxt   = used_r + need_r;
        grants_nxt = grants_r + bffa_pkg::CTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r    <= bffa_pkg::LIMIT_RESET;
      used_r     <= '0;
      grants_r   <= '0;
      releases_r <= '0;
      out_vld_r  <= 1'b0;
      for (int w = 0; w < bffa_pkg::NUM_WORDS; w++) begin
        map_r[w] <= '0;
      end
      for (int p = 0; p < bffa_pkg::MAX_PROCS; p++) begin
        held_len_r[p] <= '0;
        held_st_r[p]  <= '0;
      end
    end else begin
      if (cfg_valid) begin
        limit_r <= cfg_data;
      end
      if (out_vld_r && out_ready) begin
        out_vld_r <= 1'b0;
      end
      if (cmd.mark_step) begin
        map_r[cur_w_r] <= (cmd_r == bffa_pkg::CMD_FREE) ? (map_word & ~mask)
                                                        : (map_word | mask);
      end
      if (cmd.emit) begin
        out_vld_r  <= 1'b1;
        used_r     <= used_nxt;
        grants_r   <= grants_nxt;
        releases_r <= releases_nxt;
        if (!cmd.reject) begin
          if (cmd_r == bffa_pkg::CMD_FREE) begin
            held_len_r[proc_r] <= '0;
            held_st_r[proc_r]  <= '0;
          end else begin
            held_len_r[proc_r] <= need_r;
            held_st_r[proc_r]  <= start_r;
          end
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r  <= in_command;
      proc_r <= in_process;
      need_r <= in_blocks_needed;
    end
    if (cmd.scan_start) begin
      scan_w_r <= '0;
      run_r    <= '0;
      first_r  <= '0;
    end else if (cmd.scan_step) begin
      scan_w_r <= scan_w_r + bffa_pkg::WIDX_W'(1);
      run_r    <= run_nxt;
      first_r  <= first_nxt;
      if (hit) begin
        start_r <= hit_start;
      end
    end
    if (cmd.mark_start) begin
      lo_r    <= mark_lo;
      hi_r    <= {1'b0, mark_lo} + mark_len - bffa_pkg::CNT_W'(1);
      cur_w_r <= mark_lo[bffa_pkg::BLK_W-1:bffa_pkg::BIT_W];
    end else if (cmd.mark_step) begin
      cur_w_r <= cur_w_r + bffa_pkg::WIDX_W'(1);
    end
    if (cmd.emit) begin
      out_status           <= cmd.reject ? bffa_pkg::STATUS_REJECT : bffa_pkg::STATUS_DONE;
      out_start_block      <= (cmd.reject || cmd_r == bffa_pkg::CMD_FREE) ? '0 : start_r;
      out_used_blocks      <= used_nxt;
      out_free_blocks      <= bffa_pkg::CNT_W'(bffa_pkg::NUM_BLOCKS) - used_nxt;
      out_allocations_done <= grants_nxt;
      out_frees_done       <= releases_nxt;
    end
  end

  assign out_valid = out_vld_r;

  assign stat.is_free   = (cmd_r == bffa_pkg::CMD_FREE);
  assign stat.index_ok  = ({1'b0, proc_r} < limit_r) && (32'(proc_r) < bffa_pkg::MAX_PROCS);
  assign stat.need_zero = (need_r == '0);
  assign stat.held_zero = (held_len == '0);
  assign stat.hit       = hit;
  assign stat.scan_last = (scan_w_r == bffa_pkg::WIDX_W'(bffa_pkg::NUM_WORDS - 1));
  assign stat.mark_last = (cur_w_r == hi_r[bffa_pkg::BLK_W-1:bffa_pkg::BIT_W]);
  assign stat.out_busy  = out_vld_r && !out_ready;

endmodule

@@ src/bitmap_first_fit_block_allocator.sv @@
// Sequence: accept, check, then for an allocate one map word (8 blocks) scanned per cycle
// up to the word that completes the run, setup, one word marked or cleared per cycle over
// the run, and a finish state that registers the result once the output is not stalled.
// Throughput: one transaction at a time, the next taken the cycle after the result is
// registered; the single map read port, one word per cycle, sets the scan and mark time.
// Reset (synchronous, active low) clears map, records and counters at once; limit = 16.
module bitmap_first_fit_block_allocator (
  input  logic       clk,
  input  logic       rst_n,
  bffa_req_if.sink   in_ch,
  bffa_rsp_if.source out_ch,
  bffa_cfg_if.sink   cfg_ch
);

  bffa_pkg::bffa_cmd_t  cmd;
  bffa_pkg::bffa_stat_t stat;
  logic                 in_ready;

  assign in_ch.ready  = in_ready;
  assign cfg_ch.ready = 1'b1;

  bffa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bffa_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .stat                 (stat),
    .in_command           (in_ch.command),
    .in_process           (in_ch.process),
    .in_blocks_needed     (in_ch.blocks_needed),
    .cfg_valid            (cfg_ch.valid),
    .cfg_data             (cfg_ch.data),
    .out_ready            (out_ch.ready),
    .out_valid            (out_ch.valid),
    .out_status           (out_ch.status),
    .out_start_block      (out_ch.start_block),
    .out_used_blocks      (out_ch.used_blocks),
    .out_free_blocks      (out_ch.free_blocks),
    .out_allocations_done (out_ch.allocations_done),
    .out_frees_done       (out_ch.frees_done)
  );

  // used and free always account for every block
  a_blocks_balance: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (({1'b0, out_ch.used_blocks} + {1'b0, out_ch.free_blocks}) ==
                      (bffa_pkg::CNT_W + 1)'(bffa_pkg::NUM_BLOCKS)))
    else $error("used and free block counts do not add up");

  // a rejected transaction never reports a start block
  a_reject_start: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status == bffa_pkg::STATUS_REJECT) |->
      (out_ch.start_block == '0))
    else $error("rejected result carries a start block");

  // the controller issues at most one datapath command per cycle
  a_single_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.scan_start, cmd.scan_step, cmd.mark_start, cmd.mark_step,
              cmd.emit}))
    else $error("overlapping datapath commands");

  // a new result is never loaded over one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !(out_ch.valid && !out_ch.ready))
    else $error("result register overwritten while stalled");

endmodule
